// ----- sv/cwa_pkg.sv -----
// ----------------------------------------------------------------------------
// cwa_pkg
// Shared types, constants and helpers for the contact watch alarm.
// ----------------------------------------------------------------------------
package cwa_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned STR_W   = 7;
    localparam int unsigned TICK_W  = 8;
    localparam int unsigned IV_W    = 9;
    localparam int unsigned IDX_W   = 2;

    localparam logic [TIME_W-1:0] LOG_GAP_MS    = 32'd3000;
    localparam logic [IV_W-1:0]   CLICK_BASE_MS = 9'd360;
    localparam logic [IV_W-1:0]   CLICK_MIN_MS  = 9'd70;
    localparam logic [IV_W-1:0]   CLICK_SLOPE   = 9'd3;
    localparam logic [IV_W-1:0]   CLICK_MAX_DROP = CLICK_BASE_MS - CLICK_MIN_MS;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_ARM  = 1'b1;

    localparam logic [IDX_W-1:0] REG_LOGGING_ENABLE = 2'd0;
    localparam logic [IDX_W-1:0] REG_LED_ENABLE     = 2'd1;
    localparam logic [IDX_W-1:0] REG_SOUND_ENABLE   = 2'd2;

    typedef struct packed {
        logic               command;
        logic [TIME_W-1:0]  now_ms;
        logic [COUNT_W-1:0] contact_count;
        logic               reader_present;
        logic               detector_error;
        logic [STR_W-1:0]   field_strength;
    } item_t;

    typedef struct packed {
        logic [TIME_W-1:0] elapsed_ms;
        logic [TIME_W-1:0] first_contact_ms;
        logic              first_contact_valid;
        logic [TIME_W-1:0] last_contact_ms;
        logic              last_contact_valid;
        logic              wake_pulse;
        logic              log_pulse;
        logic              found_pulse;
        logic              gone_pulse;
        logic              led_pulse;
        logic              click_pulse;
    } result_t;

    typedef struct packed {
        logic [TIME_W-1:0]  start_time;
        logic [TIME_W-1:0]  first_time;
        logic               first_seen;
        logic [TIME_W-1:0]  last_time;
        logic               last_seen;
        logic [COUNT_W-1:0] seen_contacts;
        logic [TIME_W-1:0]  click_time;
        logic [TIME_W-1:0]  log_time;
        logic [TICK_W-1:0]  tick_count;
        logic               present_before;
    } watch_state_t;

    typedef struct packed {
        logic logging_enable;
        logic led_enable;
        logic sound_enable;
    } cfg_t;

    // 4 == 1 mod 3, so the residue follows from the sum of base-4 digits
    function automatic logic is_mult3(input logic [TICK_W-1:0] value);
        logic [3:0] digit_sum;
        digit_sum = 4'(value[1:0]) + 4'(value[3:2]) + 4'(value[5:4]) + 4'(value[7:6]);
        return (digit_sum == 4'd0) || (digit_sum == 4'd3) || (digit_sum == 4'd6) ||
               (digit_sum == 4'd9) || (digit_sum == 4'd12);
    endfunction

    function automatic logic [IV_W-1:0] click_interval(input logic [STR_W-1:0] strength);
        logic [IV_W-1:0] drop;
        drop = IV_W'(strength) * CLICK_SLOPE;
        return (drop >= CLICK_MAX_DROP) ? CLICK_MIN_MS : (CLICK_BASE_MS - drop);
    endfunction

endpackage

// ----- sv/cwa_if.sv -----
// ----------------------------------------------------------------------------
// cwa_if
// Handshake channels of the contact watch alarm: status, result, config.
// ----------------------------------------------------------------------------
interface cwa_item_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] now_ms;
    logic [31:0] contact_count;
    logic        reader_present;
    logic        detector_error;
    logic [6:0]  field_strength;

    modport source (output valid, command, now_ms, contact_count, reader_present,
                    detector_error, field_strength, input ready);
    modport sink   (input valid, command, now_ms, contact_count, reader_present,
                    detector_error, field_strength, output ready);
endinterface

interface cwa_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] elapsed_ms;
    logic [31:0] first_contact_ms;
    logic        first_contact_valid;
    logic [31:0] last_contact_ms;
    logic        last_contact_valid;
    logic        wake_pulse;
    logic        log_pulse;
    logic        found_pulse;
    logic        gone_pulse;
    logic        led_pulse;
    logic        click_pulse;

    modport source (output valid, elapsed_ms, first_contact_ms, first_contact_valid,
                    last_contact_ms, last_contact_valid, wake_pulse, log_pulse,
                    found_pulse, gone_pulse, led_pulse, click_pulse, input ready);
    modport sink   (input valid, elapsed_ms, first_contact_ms, first_contact_valid,
                    last_contact_ms, last_contact_valid, wake_pulse, log_pulse,
                    found_pulse, gone_pulse, led_pulse, click_pulse, output ready);
endinterface

interface cwa_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/cwa_step.sv -----
// ----------------------------------------------------------------------------
// cwa_step
// Next-state and result logic for one arm or status request.
// ----------------------------------------------------------------------------
module cwa_step (
    input  cwa_pkg::item_t        item,
    input  cwa_pkg::watch_state_t state,
    input  cwa_pkg::cfg_t         cfg,
    output cwa_pkg::watch_state_t state_next,
    output cwa_pkg::result_t      res
);
    import cwa_pkg::*;

    logic [TIME_W-1:0] watching;
    logic [TIME_W-1:0] log_gap;
    logic [TIME_W-1:0] click_gap;
    logic [TICK_W-1:0] tick_inc;
    logic              new_contact;
    logic              alive;

    assign tick_inc    = state.tick_count + TICK_W'(1);
    assign watching    = item.now_ms - state.start_time;
    assign log_gap     = item.now_ms - state.log_time;
    assign click_gap   = item.now_ms - state.click_time;
    assign new_contact = item.contact_count > state.seen_contacts;
    assign alive       = !item.detector_error;

    always_comb
    begin
        state_next = state;
        res        = '0;
        if (item.command == CMD_ARM)
        begin
            state_next            = '0;
            state_next.start_time = item.now_ms;
        end
        else
        begin
            state_next.tick_count = tick_inc;
            res.elapsed_ms        = watching;
            if (new_contact)
            begin
                state_next.seen_contacts = item.contact_count;
                state_next.last_time     = watching;
                state_next.last_seen     = 1'b1;
                if (!state.first_seen)
                begin
                    state_next.first_time = watching;
                    state_next.first_seen = 1'b1;
                end
                res.wake_pulse = 1'b1;
                if (cfg.logging_enable && (log_gap >= LOG_GAP_MS))
                begin
                    res.log_pulse       = 1'b1;
                    state_next.log_time = item.now_ms;
                end
            end
            if (alive)
            begin
                res.found_pulse           = item.reader_present && !state.present_before;
                res.gone_pulse            = !item.reader_present && state.present_before;
                state_next.present_before = item.reader_present;
                if (item.reader_present)
                begin
                    res.led_pulse = cfg.led_enable && is_mult3(tick_inc);
                    if (cfg.sound_enable &&
                        (click_gap >= TIME_W'(click_interval(item.field_strength))))
                    begin
                        res.click_pulse       = 1'b1;
                        state_next.click_time = item.now_ms;
                    end
                end
            end
        end
        res.first_contact_valid = state_next.first_seen;
        res.first_contact_ms    = state_next.first_seen ? state_next.first_time : '0;
        res.last_contact_valid  = state_next.last_seen;
        res.last_contact_ms     = state_next.last_seen ? state_next.last_time : '0;
    end

endmodule

// ----- sv/contact_watch_alarm.sv -----
// ----------------------------------------------------------------------------
// contact_watch_alarm
// Unattended field-detector guard: contact times, wake/log, presence alerts.
// ----------------------------------------------------------------------------
//  channel  role    payload
//  item     sink    command, now_ms, contact_count, reader_present,
//                   detector_error, field_strength
//  result   source  elapsed_ms, contact times and flags, six pulses
//  cfg      sink    index (0 logging, 1 led, 2 sound), data
//
//  One request per cycle unless the result stalls; a request is taken into the
//  input register, then its result into the result register, where it is valid.
//  Watch state updates as the request moves from the input to the result
//  register, so the next request sees it at once.
//  A stalled result holds both registers; item.ready drops only when both
//  are full. Reset clears state and sets led and sound enables.
// ----------------------------------------------------------------------------
module contact_watch_alarm (
    input  logic         clk,
    input  logic         rst_n,
    cwa_item_if.sink     item,
    cwa_result_if.source result,
    cwa_cfg_if.sink      cfg
);
    import cwa_pkg::*;

    logic         in_valid_reg;
    item_t        in_item_reg;
    logic         out_valid_reg;
    result_t      out_res_reg;
    watch_state_t state_reg;
    watch_state_t state_next;
    result_t      res_next;
    cfg_t         cfg_reg;
    logic         advance;
    logic         take_in;

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign take_in    = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    cwa_step u_step (
        .item       (in_item_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .res        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            cfg_reg       <= '{logging_enable: 1'b0, led_enable: 1'b1, sound_enable: 1'b1};
        end
        else
        begin
            if (item.ready)
                in_valid_reg <= item.valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_LOGGING_ENABLE: cfg_reg.logging_enable <= cfg.data;
                    REG_LED_ENABLE:     cfg_reg.led_enable     <= cfg.data;
                    REG_SOUND_ENABLE:   cfg_reg.sound_enable   <= cfg.data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_item_reg.command        <= item.command;
            in_item_reg.now_ms         <= item.now_ms;
            in_item_reg.contact_count  <= item.contact_count;
            in_item_reg.reader_present <= item.reader_present;
            in_item_reg.detector_error <= item.detector_error;
            in_item_reg.field_strength <= item.field_strength;
        end
        if (advance)
            out_res_reg <= res_next;
    end

    assign result.valid               = out_valid_reg;
    assign result.elapsed_ms          = out_res_reg.elapsed_ms;
    assign result.first_contact_ms    = out_res_reg.first_contact_ms;
    assign result.first_contact_valid = out_res_reg.first_contact_valid;
    assign result.last_contact_ms     = out_res_reg.last_contact_ms;
    assign result.last_contact_valid  = out_res_reg.last_contact_valid;
    assign result.wake_pulse          = out_res_reg.wake_pulse;
    assign result.log_pulse           = out_res_reg.log_pulse;
    assign result.found_pulse         = out_res_reg.found_pulse;
    assign result.gone_pulse          = out_res_reg.gone_pulse;
    assign result.led_pulse           = out_res_reg.led_pulse;
    assign result.click_pulse         = out_res_reg.click_pulse;

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_item_reg.command == CMD_ARM) |=> (state_reg.tick_count == '0) &&
            !state_reg.first_seen && !state_reg.present_before)
        else $error("arm did not clear watch state");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.log_pulse |-> out_res_reg.wake_pulse)
        else $error("log pulse without a new contact");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_res_reg.found_pulse && out_res_reg.gone_pulse))
        else $error("found and gone in one result");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.last_seen |-> state_reg.first_seen)
        else $error("last contact recorded without first contact");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for contact_watch_alarm. A queue of status and arm
// requests feeds a bursty driver; a shadow copy of the watch logic predicts
// each result, and a monitor behind a stalling receiver compares every
// field. Phases step the three enables through several settings.
// ----------------------------------------------------------------------------
module tb;
    import cwa_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 6;

    typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_PERIODIC, RX_HEAVY} rx_mode_t;

    logic clk;
    logic rst_n;

    cwa_item_if   item_ch ();
    cwa_result_if result_ch ();
    cwa_cfg_if    cfg_ch ();

    contact_watch_alarm u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    item_t        status_requests[$];
    result_t      awaited_results[$];
    watch_state_t shadow_watch;
    cfg_t         shadow_cfg;

    logic [31:0] sim_now;
    logic [31:0] sim_contacts;
    logic        sim_present;

    int burst_left;
    int gap_left;
    int n_accepted;
    int n_results;
    int n_wake, n_log, n_found, n_gone, n_led, n_click;
    int fail_count;
    int quiet_cycles;
    int rx_count;
    rx_mode_t rx_mode;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [31:0] click_gap(input logic [6:0] strength);
        int unsigned drop;
        int unsigned gap;
        drop = 3 * strength;
        gap = (drop >= 360) ? 0 : 360 - drop;
        if (gap < 70)
        begin
            gap = 70;
        end
        return gap;
    endfunction

    function automatic result_t predict_watch(input item_t req);
        result_t     res;
        logic [31:0] span;
        res = '0;
        if (req.command == CMD_ARM)
        begin
            shadow_watch = '0;
            shadow_watch.start_time = req.now_ms;
        end
        else
        begin
            shadow_watch.tick_count = shadow_watch.tick_count + 8'd1;
            span = req.now_ms - shadow_watch.start_time;
            res.elapsed_ms = span;
            if (req.contact_count > shadow_watch.seen_contacts)
            begin
                shadow_watch.seen_contacts = req.contact_count;
                shadow_watch.last_time = span;
                shadow_watch.last_seen = 1'b1;
                if (!shadow_watch.first_seen)
                begin
                    shadow_watch.first_time = span;
                    shadow_watch.first_seen = 1'b1;
                end
                res.wake_pulse = 1'b1;
                if (shadow_cfg.logging_enable &&
                    (req.now_ms - shadow_watch.log_time) >= LOG_GAP_MS)
                begin
                    res.log_pulse = 1'b1;
                    shadow_watch.log_time = req.now_ms;
                end
            end
            if (!req.detector_error)
            begin
                res.found_pulse = req.reader_present && !shadow_watch.present_before;
                res.gone_pulse = !req.reader_present && shadow_watch.present_before;
                shadow_watch.present_before = req.reader_present;
                if (req.reader_present)
                begin
                    res.led_pulse = shadow_cfg.led_enable &&
                                    ((shadow_watch.tick_count % 8'd3) == 8'd0);
                    if (shadow_cfg.sound_enable &&
                        (req.now_ms - shadow_watch.click_time) >=
                        click_gap(req.field_strength))
                    begin
                        res.click_pulse = 1'b1;
                        shadow_watch.click_time = req.now_ms;
                    end
                end
            end
        end
        res.first_contact_valid = shadow_watch.first_seen;
        res.first_contact_ms = shadow_watch.first_seen ? shadow_watch.first_time : 32'd0;
        res.last_contact_valid = shadow_watch.last_seen;
        res.last_contact_ms = shadow_watch.last_seen ? shadow_watch.last_time : 32'd0;
        return res;
    endfunction

    function automatic item_t make_status(input logic cmd, input logic [31:0] now,
                                          input logic [31:0] contacts, input logic present,
                                          input logic err, input logic [6:0] strength);
        item_t req;
        req.command = cmd;
        req.now_ms = now;
        req.contact_count = contacts;
        req.reader_present = present;
        req.detector_error = err;
        req.field_strength = strength;
        return req;
    endfunction

    function automatic logic [31:0] time_step();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1, 2, 3, 4, 5: return $urandom_range(1, 150);
            6, 7: return $urandom_range(150, 500);
            8: return $urandom_range(2500, 4000);
            default: return $urandom_range(3000, 20000);
        endcase
    endfunction

    function automatic logic [6:0] pick_strength();
        logic [6:0] edge_vals[6];
        edge_vals = '{7'd0, 7'd96, 7'd97, 7'd100, 7'd23, 7'd24};
        if ($urandom_range(0, 4) == 0)
        begin
            return edge_vals[$urandom_range(0, 5)];
        end
        return 7'($urandom_range(0, 100));
    endfunction

    task automatic gen_watch_session(input int count, input bit allow_arms, input bit open_arm);
        item_t req;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                // drop in a request with unrelated content
                req.command = (allow_arms && $urandom_range(0, 1) != 0) ? CMD_ARM : CMD_TICK;
                req.now_ms = $urandom;
                req.contact_count = $urandom;
                req.reader_present = 1'($urandom_range(0, 1));
                req.detector_error = 1'($urandom_range(0, 1));
                req.field_strength = 7'($urandom_range(0, 100));
            end
            else if ((open_arm && k == 0) || (allow_arms && $urandom_range(0, 29) == 0))
            begin
                sim_now = sim_now + time_step();
                sim_contacts = 32'd0;
                req = make_status(CMD_ARM, sim_now, $urandom, 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), 7'($urandom_range(0, 100)));
            end
            else
            begin
                sim_now = sim_now + time_step();
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5: sim_contacts = sim_contacts + $urandom_range(1, 3);
                    6: sim_contacts = (sim_contacts > 2) ? sim_contacts - 2 : sim_contacts;
                    default: sim_contacts = sim_contacts;
                endcase
                if ($urandom_range(0, 6) == 0)
                begin
                    sim_present = !sim_present;
                end
                req = make_status(CMD_TICK, sim_now, sim_contacts, sim_present,
                                  $urandom_range(0, 9) == 0, pick_strength());
            end
            status_requests.push_back(req);
        end
    endtask

    task automatic wait_all_done();
        do
            @(negedge clk);
        while (status_requests.size() != 0 || item_ch.valid || awaited_results.size() != 0);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_LOGGING_ENABLE: shadow_cfg.logging_enable = value;
            REG_LED_ENABLE:     shadow_cfg.led_enable = value;
            REG_SOUND_ENABLE:   shadow_cfg.sound_enable = value;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic logging, input logic led, input logic sound);
        write_reg(REG_LOGGING_ENABLE, logging);
        write_reg(REG_LED_ENABLE, led);
        write_reg(REG_SOUND_ENABLE, sound);
    endtask

    task automatic settle_phase();
        wait_all_done();
        repeat (4) @(posedge clk);
    endtask

    task automatic flag_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        $display("%0t mismatch on %s: expected %h, actual %h", $time, name, want, got);
        fail_count++;
    endtask

    // driver: bursts with random gaps, valid held until accepted
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        item_t req;
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            item_ch.command <= CMD_TICK;
            item_ch.now_ms <= '0;
            item_ch.contact_count <= '0;
            item_ch.reader_present <= 1'b0;
            item_ch.detector_error <= 1'b0;
            item_ch.field_strength <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                req = make_status(item_ch.command, item_ch.now_ms, item_ch.contact_count,
                                  item_ch.reader_present, item_ch.detector_error,
                                  item_ch.field_strength);
                awaited_results.push_back(predict_watch(req));
                n_accepted++;
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    item_ch.valid <= 1'b0;
                end
                else if (status_requests.size() > 0)
                begin
                    req = status_requests.pop_front();
                    item_ch.valid <= 1'b1;
                    item_ch.command <= req.command;
                    item_ch.now_ms <= req.now_ms;
                    item_ch.contact_count <= req.contact_count;
                    item_ch.reader_present <= req.reader_present;
                    item_ch.detector_error <= req.detector_error;
                    item_ch.field_strength <= req.field_strength;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: stall pattern on ready, compare against oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : monitor_proc
        result_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            rx_count <= 0;
            rx_mode <= RX_OPEN;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t unexpected result: elapsed_ms actual %h", $time,
                             result_ch.elapsed_ms);
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    n_results++;
                    if (result_ch.elapsed_ms !== want.elapsed_ms)
                        flag_field("elapsed_ms", want.elapsed_ms, result_ch.elapsed_ms);
                    if (result_ch.first_contact_ms !== want.first_contact_ms)
                        flag_field("first_contact_ms", want.first_contact_ms,
                                   result_ch.first_contact_ms);
                    if (result_ch.first_contact_valid !== want.first_contact_valid)
                        flag_field("first_contact_valid", 32'(want.first_contact_valid),
                                   32'(result_ch.first_contact_valid));
                    if (result_ch.last_contact_ms !== want.last_contact_ms)
                        flag_field("last_contact_ms", want.last_contact_ms,
                                   result_ch.last_contact_ms);
                    if (result_ch.last_contact_valid !== want.last_contact_valid)
                        flag_field("last_contact_valid", 32'(want.last_contact_valid),
                                   32'(result_ch.last_contact_valid));
                    if (result_ch.wake_pulse !== want.wake_pulse)
                        flag_field("wake_pulse", 32'(want.wake_pulse),
                                   32'(result_ch.wake_pulse));
                    if (result_ch.log_pulse !== want.log_pulse)
                        flag_field("log_pulse", 32'(want.log_pulse),
                                   32'(result_ch.log_pulse));
                    if (result_ch.found_pulse !== want.found_pulse)
                        flag_field("found_pulse", 32'(want.found_pulse),
                                   32'(result_ch.found_pulse));
                    if (result_ch.gone_pulse !== want.gone_pulse)
                        flag_field("gone_pulse", 32'(want.gone_pulse),
                                   32'(result_ch.gone_pulse));
                    if (result_ch.led_pulse !== want.led_pulse)
                        flag_field("led_pulse", 32'(want.led_pulse),
                                   32'(result_ch.led_pulse));
                    if (result_ch.click_pulse !== want.click_pulse)
                        flag_field("click_pulse", 32'(want.click_pulse),
                                   32'(result_ch.click_pulse));
                    n_wake += int'(want.wake_pulse);
                    n_log += int'(want.log_pulse);
                    n_found += int'(want.found_pulse);
                    n_gone += int'(want.gone_pulse);
                    n_led += int'(want.led_pulse);
                    n_click += int'(want.click_pulse);
                end
            end
            rx_count <= rx_count + 1;
            if (rx_count % 64 == 0)
            begin
                rx_mode <= rx_mode_t'($urandom_range(0, 3));
            end
            case (rx_mode)
                RX_OPEN:     result_ch.ready <= 1'b1;
                RX_LIGHT:    result_ch.ready <= ($urandom_range(0, 9) < 7);
                RX_PERIODIC: result_ch.ready <= (rx_count[1:0] == 2'b11);
                default:     result_ch.ready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t no progress for %0d cycles", $time, quiet_cycles);
                $display("[contact_watch_alarm] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.command = CMD_TICK;
        item_ch.now_ms = '0;
        item_ch.contact_count = '0;
        item_ch.reader_present = 1'b0;
        item_ch.detector_error = 1'b0;
        item_ch.field_strength = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_LOGGING_ENABLE;
        cfg_ch.data = 1'b0;
        shadow_watch = '0;
        shadow_cfg.logging_enable = 1'b0;
        shadow_cfg.led_enable = 1'b1;
        shadow_cfg.sound_enable = 1'b1;
        sim_now = 32'd0;
        sim_contacts = 32'd0;
        sim_present = 1'b0;
        fail_count = 0;
        quiet_cycles = 0;
        n_accepted = 0;
        n_results = 0;
        {n_wake, n_log, n_found, n_gone, n_led, n_click} = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        set_config(1'b1, 1'b1, 1'b1);
        status_requests.push_back(make_status(CMD_TICK, 32'd500, 32'd0, 1'b0, 1'b0, 7'd0));
        status_requests.push_back(make_status(CMD_ARM, 32'd1000, 32'd9, 1'b1, 1'b1, 7'd5));
        status_requests.push_back(make_status(CMD_TICK, 32'd1000, 32'd0, 1'b0, 1'b0, 7'd0));
        status_requests.push_back(make_status(CMD_TICK, 32'd1100, 32'd2, 1'b1, 1'b0, 7'd0));
        status_requests.push_back(make_status(CMD_TICK, 32'd1200, 32'd2, 1'b1, 1'b0, 7'd100));
        status_requests.push_back(make_status(CMD_TICK, 32'd4200, 32'd5, 1'b1, 1'b0, 7'd97));
        status_requests.push_back(make_status(CMD_TICK, 32'd4300, 32'd4, 1'b1, 1'b1, 7'd96));
        status_requests.push_back(make_status(CMD_TICK, 32'd4400, 32'd6, 1'b0, 1'b1, 7'd50));
        status_requests.push_back(make_status(CMD_TICK, 32'd4500, 32'd6, 1'b0, 1'b0, 7'd50));
        status_requests.push_back(make_status(CMD_TICK, 32'd4501, 32'd6, 1'b1, 1'b0, 7'd50));
        status_requests.push_back(make_status(CMD_TICK, 32'd4502, 32'd6, 1'b1, 1'b0, 7'd50));
        status_requests.push_back(make_status(CMD_TICK, 32'd4574, 32'd6, 1'b1, 1'b0, 7'd96));
        status_requests.push_back(make_status(CMD_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                                              1'b0, 7'd100));
        status_requests.push_back(make_status(CMD_TICK, 32'h0000_0010, 32'hFFFF_FFFF, 1'b1,
                                              1'b0, 7'd0));
        status_requests.push_back(make_status(CMD_ARM, 32'hFFFF_FFF0, 32'd0, 1'b0, 1'b0, 7'd0));
        status_requests.push_back(make_status(CMD_TICK, 32'h0000_0005, 32'd1, 1'b1, 1'b0, 7'd99));
        status_requests.push_back(make_status(CMD_TICK, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0,
                                              1'b1, 7'd27));
        status_requests.push_back(make_status(CMD_TICK, 32'h8000_0BB7, 32'h8000_0001, 1'b1,
                                              1'b0, 7'd100));
        status_requests.push_back(make_status(CMD_TICK, 32'h8000_0BB8, 32'h8000_0001, 1'b0,
                                              1'b0, 7'd100));
        status_requests.push_back(make_status(CMD_ARM, 32'hAAAA_5555, 32'h5555_AAAA, 1'b1,
                                              1'b0, 7'd100));
        status_requests.push_back(make_status(CMD_TICK, 32'hAAAA_5555, 32'd0, 1'b1, 1'b1, 7'd0));
        status_requests.push_back(make_status(CMD_TICK, 32'hAAAA_6000, 32'd3, 1'b1, 1'b0, 7'd24));
        settle_phase();

        sim_now = 32'd20000;
        gen_watch_session(100, 1'b1, 1'b1);
        settle_phase();

        set_config(1'b0, 1'b0, 1'b0);
        gen_watch_session(90, 1'b1, 1'b1);
        settle_phase();

        // long session without arm so the tick counter wraps
        set_config(1'b1, 1'b1, 1'b0);
        gen_watch_session(131, 1'b0, 1'b1);
        wait_all_done();
        gen_watch_session(130, 1'b0, 1'b0);
        settle_phase();

        set_config(1'b0, 1'b1, 1'b1);
        gen_watch_session(100, 1'b1, 1'b1);
        wait_all_done();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (awaited_results.size() != 0)
        begin
            $display("%0t %0d results never arrived", $time, awaited_results.size());
            fail_count++;
        end
        $display("run covered %0d requests and %0d checked results over five phases",
                 n_accepted, n_results);
        $display("pulses seen: wake %0d log %0d found %0d gone %0d led %0d click %0d",
                 n_wake, n_log, n_found, n_gone, n_led, n_click);
        if (fail_count == 0)
        begin
            $display("[contact_watch_alarm] OK");
        end
        else
        begin
            $display("[contact_watch_alarm] ERROR");
        end
        $finish;
    end

endmodule
